@@ rtl/core/selective_repeat_sender_window_unit_assert.svh @@
// Assertion macros for the selective-repeat sender window unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_UNIT_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// prop must hold at every edge outside reset
`define SRSW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");
// expr must never be true outside reset
`define SRSW_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define SRSW_ASSERT(label, clk, rst, prop)
`define SRSW_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ rtl/core/srsw_pkg.sv @@
// Shared constants, codes and types of the selective-repeat sender window unit.
// No dependencies; used by the interfaces, the output stage and the top level.
`default_nettype none

package srsw_pkg;

   localparam int WINDOW     = 32;
   localparam int RESULT_CAP = 32;
   localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int IDX_W      = $clog2(WINDOW + 1);
   localparam int CNT_W      = $clog2(RESULT_CAP + 1);

   localparam int ID_W       = 24;
   localparam int TIME_W     = 32;
   localparam int RTT_W      = 24;
   localparam int FRAC_W     = 4;
   localparam int TIMEOUT_W  = 16;
   localparam int RETX_W     = 32;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(200);

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK      = 2'd0,
      CMD_ACK       = 2'd1,
      CMD_NEW_SCAN  = 2'd2,
      CMD_RETX_SCAN = 2'd3
   } srsw_cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PACKETS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = CSR_IDX_W'(1);

   localparam logic KIND_SEND = 1'b0;
   localparam logic KIND_ACK  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [ID_W-1:0]   packet_id;
      logic              is_retransmit;
      logic              ack_new;
      logic              ack_out_of_window;
      logic [RTT_W-1:0]  smoothed_rtt;
      logic [ID_W-1:0]   window_base;
      logic [ID_W-1:0]   acks_total;
      logic [RETX_W-1:0] retransmissions;
      logic              transfer_done;
      logic              last;
   } srsw_rsp_type;

   // sequencer -> output stage
   typedef struct packed {
      logic push;
      logic flush;
   } srsw_oq_ctrl_type;

   // output stage -> sequencer
   typedef struct packed {
      logic push_ok;
      logic flush_ok;
   } srsw_oq_stat_type;

endpackage

`default_nettype wire

@@ rtl/core/srsw_ifs.sv @@
// Handshake channel interfaces: request, response and register write.
// Depends on srsw_pkg for field widths.
`default_nettype none

interface srsw_req_if;
   import srsw_pkg::*;
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [ID_W-1:0]  ack_id;
   modport source (output valid, cmd, ack_id, input ready);
   modport sink   (input valid, cmd, ack_id, output ready);
endinterface

interface srsw_rsp_if;
   import srsw_pkg::*;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [ID_W-1:0]   packet_id;
   logic              is_retransmit;
   logic              ack_new;
   logic              ack_out_of_window;
   logic [RTT_W-1:0]  smoothed_rtt;
   logic [ID_W-1:0]   window_base;
   logic [ID_W-1:0]   acks_total;
   logic [RETX_W-1:0] retransmissions;
   logic              transfer_done;
   logic              last;
   modport source (output valid, kind, packet_id, is_retransmit, ack_new, ack_out_of_window,
                   smoothed_rtt, window_base, acks_total, retransmissions, transfer_done,
                   last, input ready);
   modport sink   (input valid, kind, packet_id, is_retransmit, ack_new, ack_out_of_window,
                   smoothed_rtt, window_base, acks_total, retransmissions, transfer_done,
                   last, output ready);
endinterface

interface srsw_csr_if;
   import srsw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/core/srsw_out_stage.sv @@
// Response staging: one pending slot plus the output register.
// Depends on srsw_pkg and srsw_rsp_if.
`default_nettype none

module srsw_out_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire srsw_pkg::srsw_oq_ctrl_type ctrl,
   input  wire srsw_pkg::srsw_rsp_type   item,
   output srsw_pkg::srsw_oq_stat_type    status,
   srsw_rsp_if.source                    rsp
);
   import srsw_pkg::*;

   logic         pend_vld_ff, pend_vld_in;
   srsw_rsp_type pend_ff, pend_in;
   logic         out_vld_ff, out_vld_in;
   srsw_rsp_type out_ff, out_in;
   logic         out_free;

   // A result is held back in the pending slot so the final one of an input can be marked.
   assign out_free        = !out_vld_ff || rsp.ready;
   assign status.push_ok  = !pend_vld_ff || out_free;
   assign status.flush_ok = !pend_vld_ff || out_free;

   always_comb begin
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      if (out_vld_ff && rsp.ready) begin
         out_vld_in = 1'b0;
      end
      if (ctrl.push && status.push_ok) begin
         if (pend_vld_ff) begin
            out_in      = pend_ff;
            out_in.last = 1'b0;
            out_vld_in  = 1'b1;
         end
         pend_in     = item;
         pend_vld_in = 1'b1;
      end else if (ctrl.flush && pend_vld_ff && out_free) begin
         out_in      = pend_ff;
         out_in.last = 1'b1;
         out_vld_in  = 1'b1;
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp.valid             = out_vld_ff;
   assign rsp.kind              = out_ff.kind;
   assign rsp.packet_id         = out_ff.packet_id;
   assign rsp.is_retransmit     = out_ff.is_retransmit;
   assign rsp.ack_new           = out_ff.ack_new;
   assign rsp.ack_out_of_window = out_ff.ack_out_of_window;
   assign rsp.smoothed_rtt      = out_ff.smoothed_rtt;
   assign rsp.window_base       = out_ff.window_base;
   assign rsp.acks_total        = out_ff.acks_total;
   assign rsp.retransmissions   = out_ff.retransmissions;
   assign rsp.transfer_done     = out_ff.transfer_done;
   assign rsp.last              = out_ff.last;

endmodule

`default_nettype wire

@@ rtl/core/selective_repeat_sender_window_unit.sv @@
// Selective-repeat sender window: a tick advances time; an ack goes ACK_CHK, then FLUSH if
// repeat or out of window, else ACK_RTT, ACK_SRTT, SLIDE once per slot the base passes and
// once more, FLUSH. Scans check up to WINDOW slots, one per cycle unless output stalls, via
// the sent-time memory and the shared age subtractor. Request ready only while the sequencer
// is idle. Synchronous reset clears counters, flags and the base; total_packets resets to 0,
// timeout_ticks to 200. No clearing pass: a sent time is used only where its sent flag is set.
`default_nettype none
`include "selective_repeat_sender_window_unit_assert.svh"

module selective_repeat_sender_window_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   srsw_req_if.sink   req_if,
   srsw_rsp_if.source rsp_if,
   srsw_csr_if.sink   csr_if
);
   import srsw_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_ACK_CHK  = 7'b0000010,
      ST_ACK_RTT  = 7'b0000100,
      ST_ACK_SRTT = 7'b0001000,
      ST_SLIDE    = 7'b0010000,
      ST_SCAN     = 7'b0100000,
      ST_FLUSH    = 7'b1000000
   } state_type;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(WINDOW - 1)) ? '0 : s + SLOT_W'(1);
   endfunction

   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                  input logic [SLOT_W-1:0] off);
      logic [SLOT_W:0] sum;
      sum = {1'b0, s} + {1'b0, off};
      if (sum >= (SLOT_W + 1)'(WINDOW)) begin
         sum = sum - (SLOT_W + 1)'(WINDOW);
      end
      return sum[SLOT_W-1:0];
   endfunction

   state_type             state_ff, state_in;
   logic [ID_W-1:0]       total_ff, total_in;
   logic [TIMEOUT_W-1:0]  timeout_ff, timeout_in;
   logic [ID_W-1:0]       base_ff, base_in;
   logic [SLOT_W-1:0]     base_slot_ff, base_slot_in;
   logic [ID_W-1:0]       ack_cnt_ff, ack_cnt_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [RTT_W-1:0]      srtt_ff, srtt_in;
   logic [RETX_W-1:0]     retx_ff, retx_in;
   logic [WINDOW-1:0]     sent_ff, sent_in;
   logic [WINDOW-1:0]     acked_ff, acked_in;

   logic [ID_W-1:0]       ack_id_ff, ack_id_in;
   logic [SLOT_W-1:0]     ack_slot_ff, ack_slot_in;
   logic [RTT_W-1:0]      sample_ff, sample_in;
   logic                  take_ff, take_in;
   logic                  retx_mode_ff, retx_mode_in;
   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [SLOT_W-1:0]     scan_slot_ff, scan_slot_in;
   logic                  eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0]      eval_idx_ff, eval_idx_in;
   logic [SLOT_W-1:0]     eval_slot_ff, eval_slot_in;
   logic [CNT_W-1:0]      res_cnt_ff, res_cnt_in;

   // sent-time store
   logic [TIME_W-1:0]     time_mem [WINDOW];
   logic                  mem_we, mem_re;
   logic [SLOT_W-1:0]     mem_waddr, mem_raddr;
   logic [TIME_W-1:0]     mem_rdata_ff;

   srsw_oq_ctrl_type      oq_ctrl;
   srsw_oq_stat_type      oq_stat;
   srsw_rsp_type          oq_item;

   srsw_cmd_type          req_cmd;
   logic                  req_fire;
   logic [TIME_W-1:0]     age;
   logic                  ack_ge_base, ack_oow;
   logic [ID_W-1:0]       ack_off;
   logic [SLOT_W-1:0]     ack_slot;
   logic [RTT_W+3:0]      srtt_sum;
   logic [ID_W:0]         issue_id;
   logic                  scan_qual, scan_act, scan_stall, can_issue;
   logic [CNT_W-1:0]      cnt_next;

   assign req_cmd       = srsw_cmd_type'(req_if.cmd);
   assign req_if.ready  = (state_ff == ST_IDLE);
   assign req_fire      = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;

   // shared age subtractor: RTT sample on acks, timeout test on retransmit scans
   assign age = now_ff - mem_rdata_ff;

   assign ack_ge_base = (ack_id_ff >= base_ff);
   assign ack_off     = ack_id_ff - base_ff;
   assign ack_oow     = (ack_id_ff >= total_ff) || (ack_ge_base && (ack_off >= ID_W'(WINDOW)));
   assign ack_slot    = slot_add(base_slot_ff, ack_off[SLOT_W-1:0]);

   // 7*old + sample, then /8
   assign srtt_sum = {1'b0, srtt_ff, 3'b000} - {4'b0000, srtt_ff} + {4'b0000, sample_ff};

   assign issue_id   = {1'b0, base_ff} + (ID_W + 1)'(scan_idx_ff);
   assign scan_qual  = retx_mode_ff ?
                       (!acked_ff[eval_slot_ff] &&
                        (!sent_ff[eval_slot_ff] || (age > TIME_W'(timeout_ff)))) :
                       !sent_ff[eval_slot_ff];
   assign scan_act   = eval_vld_ff && scan_qual && (res_cnt_ff < CNT_W'(RESULT_CAP));
   assign scan_stall = scan_act && !oq_stat.push_ok;
   assign cnt_next   = res_cnt_ff + CNT_W'(scan_act);
   assign can_issue  = (scan_idx_ff < IDX_W'(WINDOW)) && (issue_id < {1'b0, total_ff}) &&
                       (cnt_next < CNT_W'(RESULT_CAP));

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      timeout_in   = timeout_ff;
      base_in      = base_ff;
      base_slot_in = base_slot_ff;
      ack_cnt_in   = ack_cnt_ff;
      now_in       = now_ff;
      srtt_in      = srtt_ff;
      retx_in      = retx_ff;
      sent_in      = sent_ff;
      acked_in     = acked_ff;
      ack_id_in    = ack_id_ff;
      ack_slot_in  = ack_slot_ff;
      sample_in    = sample_ff;
      take_in      = take_ff;
      retx_mode_in = retx_mode_ff;
      scan_idx_in  = scan_idx_ff;
      scan_slot_in = scan_slot_ff;
      eval_vld_in  = eval_vld_ff;
      eval_idx_in  = eval_idx_ff;
      eval_slot_in = eval_slot_ff;
      res_cnt_in   = res_cnt_ff;
      mem_we       = 1'b0;
      mem_waddr    = eval_slot_ff;
      mem_re       = 1'b0;
      mem_raddr    = scan_slot_ff;
      oq_ctrl      = '0;

      if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            CSR_TOTAL_PACKETS: total_in   = csr_if.wdata[ID_W-1:0];
            CSR_TIMEOUT_TICKS: timeout_in = csr_if.wdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_cmd)
                  CMD_TICK: now_in = now_ff + TIME_W'(1);
                  CMD_ACK: begin
                     ack_id_in = req_if.ack_id;
                     state_in  = ST_ACK_CHK;
                  end
                  CMD_NEW_SCAN, CMD_RETX_SCAN: begin
                     retx_mode_in = (req_cmd == CMD_RETX_SCAN);
                     scan_idx_in  = '0;
                     scan_slot_in = base_slot_ff;
                     eval_vld_in  = 1'b0;
                     res_cnt_in   = '0;
                     state_in     = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_ACK_CHK: begin
            if (ack_oow || !ack_ge_base || acked_ff[ack_slot]) begin
               oq_ctrl.push = 1'b1;
               state_in     = ST_FLUSH;
            end else begin
               acked_in[ack_slot] = 1'b1;
               ack_cnt_in         = ack_cnt_ff + ID_W'(1);
               ack_slot_in        = ack_slot;
               mem_re             = 1'b1;
               mem_raddr          = ack_slot;
               state_in           = ST_ACK_RTT;
            end
         end
         ST_ACK_RTT: begin
            take_in   = sent_ff[ack_slot_ff];
            sample_in = (|age[TIME_W-1:RTT_W-FRAC_W]) ? '1 :
                        {age[RTT_W-FRAC_W-1:0], FRAC_W'(0)};
            state_in  = ST_ACK_SRTT;
         end
         ST_ACK_SRTT: begin
            if (take_ff) begin
               srtt_in = (srtt_ff == '0) ? sample_ff : srtt_sum[RTT_W+2:3];
            end
            state_in = ST_SLIDE;
         end
         ST_SLIDE: begin
            if ((base_ff < total_ff) && acked_ff[base_slot_ff]) begin
               acked_in[base_slot_ff] = 1'b0;
               sent_in[base_slot_ff]  = 1'b0;
               base_in                = base_ff + ID_W'(1);
               base_slot_in           = slot_inc(base_slot_ff);
            end else begin
               oq_ctrl.push = 1'b1;
               state_in     = ST_FLUSH;
            end
         end
         ST_SCAN: begin
            if (!scan_stall) begin
               if (scan_act) begin
                  oq_ctrl.push          = 1'b1;
                  sent_in[eval_slot_ff] = 1'b1;
                  mem_we                = 1'b1;
                  res_cnt_in            = cnt_next;
                  if (sent_ff[eval_slot_ff]) begin
                     retx_in = retx_ff + RETX_W'(1);
                  end
               end
               if (can_issue) begin
                  mem_re       = 1'b1;
                  eval_vld_in  = 1'b1;
                  eval_idx_in  = scan_idx_ff;
                  eval_slot_in = scan_slot_ff;
                  scan_idx_in  = scan_idx_ff + IDX_W'(1);
                  scan_slot_in = slot_inc(scan_slot_ff);
               end else begin
                  eval_vld_in = 1'b0;
                  state_in    = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            oq_ctrl.flush = 1'b1;
            if (oq_stat.flush_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // result snapshot: state after the event of this result
      oq_item.kind              = KIND_SEND;
      oq_item.packet_id         = ID_W'({1'b0, base_ff} + (ID_W + 1)'(eval_idx_ff));
      oq_item.is_retransmit     = sent_ff[eval_slot_ff];
      oq_item.ack_new           = 1'b0;
      oq_item.ack_out_of_window = 1'b0;
      oq_item.smoothed_rtt      = srtt_ff;
      oq_item.window_base       = base_ff;
      oq_item.acks_total        = ack_cnt_ff;
      oq_item.retransmissions   = retx_in;
      oq_item.transfer_done     = (base_ff >= total_ff);
      oq_item.last              = 1'b0;
      if (state_ff != ST_SCAN) begin
         oq_item.kind              = KIND_ACK;
         oq_item.packet_id         = ack_id_ff;
         oq_item.is_retransmit     = 1'b0;
         oq_item.ack_new           = (state_ff == ST_SLIDE);
         oq_item.ack_out_of_window = (state_ff == ST_ACK_CHK) && ack_oow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         base_ff      <= '0;
         base_slot_ff <= '0;
         ack_cnt_ff   <= '0;
         now_ff       <= '0;
         srtt_ff      <= '0;
         retx_ff      <= '0;
         sent_ff      <= '0;
         acked_ff     <= '0;
         eval_vld_ff  <= 1'b0;
         res_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         timeout_ff   <= timeout_in;
         base_ff      <= base_in;
         base_slot_ff <= base_slot_in;
         ack_cnt_ff   <= ack_cnt_in;
         now_ff       <= now_in;
         srtt_ff      <= srtt_in;
         retx_ff      <= retx_in;
         sent_ff      <= sent_in;
         acked_ff     <= acked_in;
         eval_vld_ff  <= eval_vld_in;
         res_cnt_ff   <= res_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ack_id_ff    <= ack_id_in;
      ack_slot_ff  <= ack_slot_in;
      sample_ff    <= sample_in;
      take_ff      <= take_in;
      retx_mode_ff <= retx_mode_in;
      scan_idx_ff  <= scan_idx_in;
      scan_slot_ff <= scan_slot_in;
      eval_idx_ff  <= eval_idx_in;
      eval_slot_ff <= eval_slot_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         time_mem[mem_waddr] <= now_ff;
      end
      if (mem_re) begin
         mem_rdata_ff <= time_mem[mem_raddr];
      end
   end

   srsw_out_stage u_out (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (oq_ctrl),
      .item   (oq_item),
      .status (oq_stat),
      .rsp    (rsp_if)
   );

   `SRSW_ASSERT(a_base_moves_in_slide, clock, reset, state_ff != ST_SLIDE |=> base_ff == $past(base_ff))
   `SRSW_ASSERT(a_retx_moves_in_scan, clock, reset, state_ff != ST_SCAN |=> retx_ff == $past(retx_ff))
   `SRSW_ASSERT(a_rsp_held, clock, reset,
                rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.packet_id))
   `SRSW_ASSERT_NEVER(a_scan_cap, clock, reset, res_cnt_ff > CNT_W'(RESULT_CAP))

endmodule

`default_nettype wire
